>>> design/csra_pkg.sv
`timescale 1ns / 1ps

package csra_pkg;

   // Fixed field widths
   localparam int LEN_W       = 4;   // run_length
   localparam int SLOT_W      = 6;   // free_start, start_slot
   localparam int SPAN_W      = 7;   // base + length, no wrap
   localparam int REQ_TDATA_W = 16;  // run_length + free_start, padded to bytes
   localparam int RSP_TDATA_W = 8;   // start_slot + failed, padded to bytes

   // Request kinds carried on req_tuser
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;    // capture request beat, restart scan
      logic scan_step;   // advance scan pointer by one slot
      logic hit_latch;   // record start of found run
      logic apply_set;   // mark run taken
      logic apply_clear; // mark run free
      logic rsp_load;    // move result into output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_free;     // captured request is a free
      logic len_ok;      // allocate length is nonzero and within limit
      logic hit;         // current slot completes a fitting run
      logic last;        // scan pointer sits on the last slot
   } status_type;

endpackage

>>> design/csra_datapath.sv
`timescale 1ns / 1ps

module csra_datapath
   import csra_pkg::*;
#(
   parameter int NUM_SLOTS = 40,
   parameter int MAX_RUN   = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    req_mode,
   input  logic [LEN_W-1:0]        req_run_length,
   input  logic [SLOT_W-1:0]       req_free_start,
   output logic [SLOT_W-1:0]       rsp_start_slot,
   output logic                    rsp_failed
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [LEN_W:0]   MAX_LEN  = (LEN_W + 1)'(MAX_RUN);

   logic [NUM_SLOTS-1:0] map_ff, map_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic [SLOT_W-1:0]    base_ff, base_in;
   logic [LEN_W-1:0]     len_ff;
   logic                 mode_ff;
   logic                 fail_ff, fail_in;
   logic [SLOT_W-1:0]    rsp_start_ff;
   logic                 rsp_fail_ff;

   logic [LEN_W:0]       cnt_next;
   logic [LEN_W-1:0]     eff_len;
   logic [SPAN_W-1:0]    span_end;
   logic [NUM_SLOTS-1:0] run_mask;
   logic                 slot_free;
   logic [SPAN_W-1:0]    hit_start;

   // Scan status
   assign slot_free = ~map_ff[idx_ff];
   assign cnt_next  = {1'b0, cnt_ff} + (LEN_W + 1)'(1);
   assign hit_start = SPAN_W'(idx_ff) + SPAN_W'(1) - SPAN_W'(len_ff);

   assign status.is_free = (mode_ff == MODE_FREE);
   assign status.len_ok  = (len_ff != '0) && ({1'b0, len_ff} <= MAX_LEN);
   assign status.hit     = slot_free && (cnt_next == {1'b0, len_ff});
   assign status.last    = (idx_ff == LAST_IDX);

   // Run mask: slots base .. base+len-1, len capped at MAX_RUN, anything past the map dropped
   assign eff_len  = ({1'b0, len_ff} > MAX_LEN) ? LEN_W'(MAX_LEN) : len_ff;
   assign span_end = SPAN_W'(base_ff) + SPAN_W'(eff_len);

   for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_mask
      assign run_mask[j] = (SPAN_W'(j) >= SPAN_W'(base_ff)) && (SPAN_W'(j) < span_end);
   end

   // Next-state of datapath registers
   always_comb begin
      map_in  = map_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      base_in = base_ff;
      fail_in = fail_ff;
      if (cmd.load_req) begin
         idx_in  = '0;
         cnt_in  = '0;
         base_in = req_free_start;
         fail_in = (req_mode == MODE_ALLOC);
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         cnt_in = slot_free ? cnt_next[LEN_W-1:0] : '0;
      end
      if (cmd.hit_latch) begin
         base_in = hit_start[SLOT_W-1:0];
         fail_in = 1'b0;
      end
      if (cmd.apply_set) begin
         map_in = map_ff | run_mask;
      end
      if (cmd.apply_clear) begin
         map_in = map_ff & ~run_mask;
      end
   end

   // Slot map, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      base_ff <= base_in;
      fail_ff <= fail_in;
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         len_ff  <= req_run_length;
      end
      if (cmd.rsp_load) begin
         rsp_start_ff <= (mode_ff == MODE_FREE || fail_ff) ? '0 : base_ff;
         rsp_fail_ff  <= fail_ff;
      end
   end

   assign rsp_start_slot = rsp_start_ff;
   assign rsp_failed     = rsp_fail_ff;

endmodule

>>> design/csra_ctrl.sv
`timescale 1ns / 1ps

module csra_ctrl
   import csra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output register can take a result this cycle
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            // first cycle after capture: free applies here, allocate decides
            if (status.is_free) begin
               cmd.apply_clear = 1'b1;
               state_in        = ST_DONE;
            end else if (status.len_ok) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.hit_latch = 1'b1;
               state_in      = ST_MARK;
            end else if (status.last) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.apply_set = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> design/contiguous_slot_run_allocator_unit.sv
`timescale 1ns / 1ps
// Sequence: a free clears its run and then loads its result; an allocate with a valid
// length scans the map one slot per cycle, marks the run it finds and then loads its
// result. Loading waits while the output register is full. One request is in flight
// at a time; a new beat is taken while the previous result waits in the output register.
// Reset (synchronous, active high) marks every slot free and empties the output.
module contiguous_slot_run_allocator_unit
   import csra_pkg::*;
#(
   parameter int NUM_SLOTS = 40,
   parameter int MAX_RUN   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [3:0] run_length, [9:4] free_start
   input  logic                   req_tuser,   // [0] mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [5:0] start_slot, [6] failed
);

   cmd_type           cmd;
   status_type        status;
   logic [SLOT_W-1:0] start_slot;
   logic              failed;

   csra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   csra_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .MAX_RUN   (MAX_RUN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_tuser),
      .req_run_length (req_tdata[LEN_W-1:0]),
      .req_free_start (req_tdata[LEN_W+SLOT_W-1:LEN_W]),
      .rsp_start_slot (start_slot),
      .rsp_failed     (failed)
   );

   // Result beat, zero padded to a byte
   assign rsp_tdata = {(RSP_TDATA_W - SLOT_W - 1)'(0), failed, start_slot};

endmodule
